### rtl/mtdl_pkg.sv
// ----------------------------------------------------------------------------
// mtdl_pkg
// Shared types, widths and constants of the multi-tap delay line.
// ----------------------------------------------------------------------------
package mtdl_pkg;

  // store geometry and tap count
  localparam int BUF_SIZE  = 4096;
  localparam int NUM_TAPS  = 4;
  localparam int TAP_SLOTS = 4;
  localparam int ADDR_W    = $clog2(BUF_SIZE);
  localparam int TAP_W     = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int SLOT_W    = $clog2(TAP_SLOTS);

  // field widths and arithmetic
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 12;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int GAIN_SHIFT = 14;
  localparam int QUOT_W     = ACC_W - GAIN_SHIFT;

  // register port
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;

  // register map: delays first, then gains
  localparam logic [REG_IDX_W-1:0] REG_DELAY_BASE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_BASE  = 3'd4;

  // input word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end_in;
  } in_t;

  // result word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       block_end_out;
  } out_t;

  // tap settings
  typedef struct packed {
    logic [TAP_SLOTS-1:0][DELAY_W-1:0] delay;
    logic [TAP_SLOTS-1:0][GAIN_W-1:0]  gain;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic             in_load;
    logic             wr_en;
    logic             acc_clr;
    logic             rd_en;
    logic [TAP_W-1:0] tap_idx;
    logic             out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

  // delays that do not fit the store act as zero
  function automatic logic [ADDR_W-1:0] eff_delay(input logic [DELAY_W-1:0] d);
    logic [31:0] dw;
    dw = 32'(d);
    if (dw >= 32'(BUF_SIZE)) begin
      return '0;
    end
    return dw[ADDR_W-1:0];
  endfunction

endpackage

### rtl/mtdl_ram.sv
// ----------------------------------------------------------------------------
// mtdl_ram
// Generic single-port RAM, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module mtdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write or read the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/mtdl_regs.sv
// ----------------------------------------------------------------------------
// mtdl_regs
// Tap delay and gain registers behind the APB-style write/read port.
// ----------------------------------------------------------------------------
module mtdl_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mtdl_pkg::PADDR_W-1:0]    paddr,
  input  logic [mtdl_pkg::PDATA_W-1:0]    pwdata,
  output logic [mtdl_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output mtdl_pkg::cfg_t                  cfg
);
  import mtdl_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] idx;
  logic [REG_IDX_W-1:0] gain_off;
  logic                 wr_stb;

  assign idx      = paddr[PADDR_W-1:2];
  assign gain_off = idx - REG_GAIN_BASE;
  assign wr_stb   = psel & penable & pwrite & pready;
  assign pready   = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_stb) begin
      if (idx < REG_GAIN_BASE) begin
        cfg_r.delay[SLOT_W'(idx - REG_DELAY_BASE)] <= pwdata[DELAY_W-1:0];
      end else begin
        cfg_r.gain[SLOT_W'(gain_off)] <= pwdata[GAIN_W-1:0];
      end
    end
  end

  // read back, gains sign extended
  always_comb begin
    if (idx < REG_GAIN_BASE) begin
      prdata = PDATA_W'(cfg_r.delay[SLOT_W'(idx - REG_DELAY_BASE)]);
    end else begin
      prdata = PDATA_W'($signed(cfg_r.gain[SLOT_W'(gain_off)]));
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/mtdl_ctrl.sv
// ----------------------------------------------------------------------------
// mtdl_ctrl
// Sequencer: store the word, read the taps, drain the MAC, hand off result.
// ----------------------------------------------------------------------------
module mtdl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mtdl_pkg::ctrl_sts_t   sts,
  output mtdl_pkg::ctrl_cmd_t   cmd
);
  import mtdl_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WRITE  = 6'b000010,
    ST_READ   = 6'b000100,
    ST_DRAIN1 = 6'b001000,
    ST_DRAIN2 = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;

  // state and tap counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    tap_nxt     = tap_r;
    cmd         = '0;
    cmd.tap_idx = tap_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr_en   = 1'b1;
        cmd.acc_clr = 1'b1;
        tap_nxt     = '0;
        state_nxt   = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        if (tap_r == TAP_W'(NUM_TAPS - 1)) begin
          state_nxt = ST_DRAIN1;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      ST_DRAIN1: begin
        state_nxt = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/mtdl_dp.sv
// ----------------------------------------------------------------------------
// mtdl_dp
// Sample store, write pointer, tap address, multiply-accumulate, output word.
// ----------------------------------------------------------------------------
module mtdl_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mtdl_pkg::in_t         in_data,
  input  mtdl_pkg::cfg_t        cfg,
  input  mtdl_pkg::ctrl_cmd_t   cmd,
  output mtdl_pkg::ctrl_sts_t   sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mtdl_pkg::out_t        out_data
);
  import mtdl_pkg::*;

  in_t                      in_r;
  logic [ADDR_W-1:0]        wp_r;
  logic                     full_r;
  logic [ADDR_W-1:0]        dly;
  logic [ADDR_W:0]          rp_wide;
  logic [ADDR_W-1:0]        rp;
  logic                     rp_ok;
  logic [ADDR_W-1:0]        ram_addr;
  logic [SAMPLE_W-1:0]      ram_rdata;
  logic                     rd_vld_r;
  logic                     rd_ok_r;
  logic [TAP_W-1:0]         tap_d_r;
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [GAIN_W-1:0]   gain;
  logic signed [PROD_W-1:0]   prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_sh;
  logic [QUOT_W-1:0]        quot;
  logic [SAMPLE_W-1:0]      sat;
  logic                     out_valid_r;
  out_t                     out_r;

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      in_r <= in_data;
    end
  end

  // write pointer and wrap flag, entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (cmd.out_load) begin
      if (wp_r == ADDR_W'(BUF_SIZE - 1)) begin
        wp_r   <= '0;
        full_r <= 1'b1;
      end else begin
        wp_r <= wp_r + 1'b1;
      end
    end
  end

  // tap read address, wrapped backward from the write pointer
  assign dly     = eff_delay(cfg.delay[SLOT_W'(cmd.tap_idx)]);
  assign rp_wide = (wp_r >= dly) ? ({1'b0, wp_r} - {1'b0, dly})
                                 : ({1'b0, wp_r} + (ADDR_W+1)'(BUF_SIZE) - {1'b0, dly});
  assign rp      = rp_wide[ADDR_W-1:0];
  assign rp_ok   = full_r | (rp <= wp_r);
  assign ram_addr = cmd.wr_en ? wp_r : rp;

  mtdl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUF_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .addr  (ram_addr),
    .wdata (in_r.sample_in),
    .rdata (ram_rdata)
  );

  // read pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.rd_en;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= rp_ok;
    tap_d_r <= cmd.tap_idx;
  end

  // product stage
  assign smp  = rd_ok_r ? signed'(ram_rdata) : '0;
  assign gain = signed'(cfg.gain[SLOT_W'(tap_d_r)]);

  always_ff @(posedge clk) begin
    prod_r <= smp * gain;
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // floor shift and saturate to sample width
  assign acc_sh = acc_r >>> GAIN_SHIFT;
  assign quot   = acc_sh[QUOT_W-1:0];

  always_comb begin
    if (quot[QUOT_W-1:SAMPLE_W-1] == '0 || quot[QUOT_W-1:SAMPLE_W-1] == '1) begin
      sat = quot[SAMPLE_W-1:0];
    end else if (quot[QUOT_W-1]) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.left_out      <= signed'(sat);
      out_r.right_out     <= signed'(sat);
      out_r.block_end_out <= in_r.block_end_in;
    end
  end

  assign sts.out_free = ~out_valid_r | out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

### rtl/multi_tap_delay_line.sv
// ----------------------------------------------------------------------------
// multi_tap_delay_line
// Mono four-tap delay over a circular sample store, duplicated stereo output.
// ----------------------------------------------------------------------------
//  channel  ports                            word
//  in       in_valid/in_ready/in_data        sample_in, block_end_in
//  out      out_valid/out_ready/out_data     left_out, right_out, block_end_out
//  cfg      psel/penable/pwrite/paddr/...    tap delays and gains, 4*index
//
//  Each word passes through accept, store write, four tap reads, two drain steps
//  for the multiply-accumulate, and result load; the single-port store keeps write and reads apart.
//  Store contents unwritten since reset read as zero through a wrap flag.
//  A new word is accepted while the previous result waits in the output register;
//  a stalled output holds the next result in the load step.
// ----------------------------------------------------------------------------
module multi_tap_delay_line (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mtdl_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mtdl_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtdl_pkg::PADDR_W-1:0]  paddr,
  input  logic [mtdl_pkg::PDATA_W-1:0]  pwdata,
  output logic [mtdl_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import mtdl_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // tap registers
  mtdl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  mtdl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store and arithmetic
  mtdl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
